// ===== design/sdtq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtq_pkg: shared types and constants of the sorted deadline timer queue
// Field widths, mode codes, item structs and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package sdtq_pkg;
    localparam int NUM_TIMERS = 16;
    localparam int TIME_BITS  = 48;
    localparam int SLOT_BITS  = $clog2(NUM_TIMERS);
    localparam int CNT_BITS   = $clog2(NUM_TIMERS + 1);
    localparam int ID_BITS    = 4;
    localparam int DELAY_BITS = 24;
    localparam int OUT_BITS   = 48;
    localparam int US_PER_MS  = 1000;

    localparam logic [1:0] MODE_ARM    = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    typedef struct packed {
        logic [1:0]            mode;
        logic [ID_BITS-1:0]    timer_id;
        logic [DELAY_BITS-1:0] delay_ms;
        logic [47:0]           now_us;
    } t_in_item;

    typedef struct packed {
        logic                kind;
        logic [ID_BITS-1:0]  expired_id;
        logic [OUT_BITS-1:0] next_interval_us;
        logic                queue_empty;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic load;       // capture input item, start deadline product
        logic calc_dl;    // form saturated deadline
        logic scan_clr;   // reset scan index and flags
        logic scan_step;  // examine one slot
        logic rm_shift;   // shift one slot down to close gap
        logic ins_shift;  // shift one slot up to open gap
        logic ins_write;  // write new timer
        logic pop_head;   // set up removal of head slot
        logic emit_exp;   // present expired notice
        logic emit_stat;  // present status
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       scan_done;
        logic       found;
        logic       shift_done;
        logic       full;
        logic       head_due;
        logic       out_busy;
    } t_sts;
endpackage

// ===== design/sdtq_if.sv =====
// ----------------------------------------------------------------------------
// sdtq_if: valid/ready channel carrying one payload
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface sdtq_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/sdtq_datapath.sv =====
// ----------------------------------------------------------------------------
// sdtq_datapath: slot store, deadline arithmetic and output register
// Sorted slot arrays walked one slot per cycle under controller command.
// ----------------------------------------------------------------------------
module sdtq_datapath import sdtq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    logic [TIME_BITS-1:0] r_dl [NUM_TIMERS];
    logic [ID_BITS-1:0]   r_own [NUM_TIMERS];
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [SLOT_BITS-1:0] r_idx;
    logic [CNT_BITS-1:0]  r_pos;
    logic                 r_found;
    logic                 r_pos_set;
    logic [1:0]           r_mode;
    logic [ID_BITS-1:0]   r_id;
    logic [TIME_BITS-1:0] r_now;
    logic [33:0]          r_prod;
    logic [TIME_BITS-1:0] r_new;
    logic                 r_valid;
    t_out_item            r_out;
    logic [TIME_BITS:0]   w_sum;
    logic [CNT_BITS-1:0]  w_idx_ext;
    logic [TIME_BITS-1:0] w_head_dl;
    logic [TIME_BITS-1:0] w_ivl;

    assign w_idx_ext = CNT_BITS'(r_idx);
    assign w_sum     = {1'b0, r_now} + (TIME_BITS+1)'(r_prod);
    assign w_head_dl = r_dl[0];
    assign w_ivl     = (w_head_dl > r_now) ? (w_head_dl - r_now) : '0;

    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.scan_done  = (w_idx_ext + 1'b1 >= r_cnt) || r_cnt == '0;
        o_sts.found      = r_found;
        o_sts.shift_done = (r_mode == MODE_ARM && r_found == 1'b0) ?
                           (r_pos_set && w_idx_ext <= r_pos) :
                           (w_idx_ext + 1'b1 >= r_cnt);
        o_sts.full       = (r_cnt == CNT_BITS'(NUM_TIMERS));
        o_sts.head_due   = (r_cnt != '0) && (r_now > w_head_dl);
        o_sts.out_busy   = r_valid && !i_ready;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.rm_shift && o_sts.shift_done) n_cnt = r_cnt - 1'b1;
        if (i_cmd.ins_write) n_cnt = r_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (r_valid && i_ready) r_valid <= 1'b0;
            if (i_cmd.emit_exp || i_cmd.emit_stat) r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_item.mode;
            r_id   <= i_item.timer_id;
            r_now  <= TIME_BITS'(i_item.now_us);
            r_prod <= 34'(i_item.delay_ms) * 34'(US_PER_MS);
        end
        if (i_cmd.calc_dl) begin
            r_new <= w_sum[TIME_BITS] ? '1 : w_sum[TIME_BITS-1:0];
        end
        if (i_cmd.scan_clr) begin
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_pos_set <= 1'b0;
            r_pos     <= r_cnt;
        end
        if (i_cmd.scan_step) begin
            if (!r_found && r_cnt != '0 && r_own[r_idx] == r_id) begin
                r_found <= 1'b1;
                r_pos   <= w_idx_ext;
            end
            if (!o_sts.scan_done) r_idx <= r_idx + 1'b1;
            else if (r_found) r_idx <= r_pos[SLOT_BITS-1:0];
            else if (!(r_cnt != '0 && r_own[r_idx] == r_id)) r_idx <= '0;
        end
        if (i_cmd.rm_shift) begin
            if (!o_sts.shift_done) begin
                r_dl[r_idx]  <= r_dl[r_idx + 1'b1];
                r_own[r_idx] <= r_own[r_idx + 1'b1];
                r_idx        <= r_idx + 1'b1;
            end else begin
                r_found   <= 1'b0;
                r_pos_set <= 1'b0;
                r_idx     <= '0;
                r_pos     <= n_cnt;
            end
        end
        if (i_cmd.ins_shift) begin
            // first pass finds position, second opens the gap from the top
            if (!r_pos_set) begin
                if (w_idx_ext >= r_cnt || !(r_new > r_dl[r_idx])) begin
                    r_pos     <= w_idx_ext;
                    r_pos_set <= 1'b1;
                    r_idx     <= r_cnt[SLOT_BITS-1:0];
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (w_idx_ext > r_pos) begin
                r_dl[r_idx]  <= r_dl[r_idx - 1'b1];
                r_own[r_idx] <= r_own[r_idx - 1'b1];
                r_idx        <= r_idx - 1'b1;
            end
        end
        if (i_cmd.ins_write) begin
            r_dl[r_pos[SLOT_BITS-1:0]]  <= r_new;
            r_own[r_pos[SLOT_BITS-1:0]] <= r_id;
        end
        if (i_cmd.pop_head) begin
            r_idx <= '0;
            r_mode <= MODE_CANCEL;
            r_id   <= r_own[0];
            r_found <= 1'b1;
            r_pos  <= '0;
        end
        if (i_cmd.emit_exp) begin
            r_out <= '{kind: 1'b0, expired_id: r_own[0], next_interval_us: '0,
                       queue_empty: 1'b0, last: 1'b0};
        end
        if (i_cmd.emit_stat) begin
            r_out <= '{kind: 1'b1, expired_id: '0,
                       next_interval_us: (r_cnt == '0) ? '0 : OUT_BITS'(w_ivl),
                       queue_empty: (r_cnt == '0), last: 1'b1};
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;
endmodule

// ===== design/sdtq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sdtq_ctrl: sequencer for arm, cancel and tick
// Steps the datapath through scan, removal, insertion and result output.
// ----------------------------------------------------------------------------
module sdtq_ctrl import sdtq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_CALC, S_SCAN, S_RM, S_INS, S_WRITE, S_TICK, S_POP, S_STAT, S_WAIT
    } t_state;

    t_state r_state, n_state;
    logic   r_tick_mode, n_tick_mode;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_tick_mode = r_tick_mode;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc_dl = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_tick_mode   = (i_sts.mode == MODE_TICK);
                if (i_sts.mode inside {MODE_ARM, MODE_CANCEL}) n_state = S_SCAN;
                else if (i_sts.mode == MODE_TICK) n_state = S_TICK;
                else n_state = S_STAT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.found) n_state = S_RM;
                else if (i_sts.mode == MODE_ARM && !i_sts.full) n_state = S_INS;
                else n_state = S_STAT;
            end
            S_RM: begin
                o_cmd.rm_shift = 1'b1;
                if (i_sts.shift_done) begin
                    if (r_tick_mode) n_state = S_TICK;
                    else if (i_sts.mode == MODE_ARM) n_state = S_INS;
                    else n_state = S_STAT;
                end
            end
            S_INS: begin
                o_cmd.ins_shift = 1'b1;
                if (i_sts.shift_done) n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.ins_write = 1'b1;
                n_state = S_STAT;
            end
            S_TICK: begin
                if (!i_sts.out_busy) begin
                    if (i_sts.head_due) begin
                        o_cmd.emit_exp = 1'b1;
                        n_state = S_POP;
                    end else begin
                        n_state = S_STAT;
                    end
                end
            end
            S_POP: begin
                o_cmd.pop_head = 1'b1;
                n_state = S_RM;
            end
            S_STAT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit_stat = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick_mode <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick_mode <= n_tick_mode;
        end
    end
endmodule

// ===== design/sorted_deadline_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue: timers kept in deadline order
// Arm, cancel and tick transactions with notices and a status result.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  i_item  | in  | mode, timer_id, delay_ms, now_us
//  o_item  | out | kind, expired_id, next_interval_us, queue_empty, last
//
//  One transaction at a time; the slot walk, one slot per cycle, scans for the
//  id, closes the gap of a removed timer and opens one for a new deadline; a
//  tick pops each expired head in turn, closing the gap behind it.
//  Reset clears the controller, the armed count and the output valid; slots need no clearing.
//  A stalled output holds the sequencer before each result.
module sorted_deadline_timer_queue import sdtq_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    sdtq_if.sink   i_item,
    sdtq_if.source o_item
);
    t_cmd w_cmd;
    t_sts w_sts;

    sdtq_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sdtq_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_item  (i_item.payload),
        .o_valid (o_item.valid),
        .i_ready (o_item.ready),
        .o_item  (o_item.payload)
    );
endmodule

// ===== design/sdtq_checker.sv =====
// ----------------------------------------------------------------------------
// sdtq_checker: port-level checks of the timer queue
// Output channel behaviour and status consistency.
// ----------------------------------------------------------------------------
module sdtq_checker import sdtq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      i_in_ready,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))
        else $error("stalled result changed");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out.kind == i_out.last)
        else $error("last and kind differ");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.queue_empty |-> i_out.next_interval_us == '0)
        else $error("interval on empty queue");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out.last |-> !i_in_ready)
        else $error("input taken mid transaction");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken twice in a row");
endmodule

bind sorted_deadline_timer_queue sdtq_checker u_chk (
    .i_clk, .i_rst_n,
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_item.valid),
    .i_out_ready (o_item.ready),
    .i_out       (o_item.payload)
);

// ===== dv/sdtq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdtq_tb_checker: prediction and comparison for the sorted deadline timer queue
// Watches the input and output channels, keeps its own sorted timer list,
// predicts the notices and status of every input transaction and compares.
// ----------------------------------------------------------------------------
module sdtq_tb_checker import sdtq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_notices
);
    localparam logic [TIME_BITS-1:0] DEADLINE_MAX = '1;

    logic [TIME_BITS-1:0] timer_deadline[NUM_TIMERS];
    logic [ID_BITS-1:0]   timer_owner[NUM_TIMERS];
    int                   armed;
    t_out_item            expected_results[$];

    function automatic void drop_at(int pos);
        for (int i = pos; i + 1 < armed; i++) begin
            timer_deadline[i] = timer_deadline[i+1];
            timer_owner[i]    = timer_owner[i+1];
        end
        if (armed > 0) armed--;
    endfunction

    function automatic void unarm(logic [ID_BITS-1:0] id);
        for (int i = 0; i < armed; i++) begin
            if (timer_owner[i] == id) begin
                drop_at(i);
                return;
            end
        end
    endfunction

    function automatic void predict_timers(t_in_item it);
        logic [63:0]          sum;
        logic [TIME_BITS-1:0] dl;
        logic [TIME_BITS-1:0] now;
        t_out_item            r;
        int                   pos;
        now = it.now_us;
        if (it.mode == MODE_ARM) begin
            sum = 64'(now) + 64'(it.delay_ms) * 64'(US_PER_MS);
            dl  = (sum > 64'(DEADLINE_MAX)) ? DEADLINE_MAX : sum[TIME_BITS-1:0];
            unarm(it.timer_id);
            if (armed < NUM_TIMERS) begin
                pos = 0;
                while (pos < armed && dl > timer_deadline[pos]) pos++;
                for (int i = armed; i > pos; i--) begin
                    timer_deadline[i] = timer_deadline[i-1];
                    timer_owner[i]    = timer_owner[i-1];
                end
                timer_deadline[pos] = dl;
                timer_owner[pos]    = it.timer_id;
                armed++;
            end
        end else if (it.mode == MODE_CANCEL) begin
            unarm(it.timer_id);
        end else if (it.mode == MODE_TICK) begin
            while (armed > 0 && now > timer_deadline[0]) begin
                r = '0;
                r.expired_id = timer_owner[0];
                expected_results.push_back(r);
                drop_at(0);
            end
        end
        r = '0;
        r.kind = 1'b1;
        r.last = 1'b1;
        r.queue_empty = (armed == 0);
        if (armed > 0 && timer_deadline[0] > now)
            r.next_interval_us = timer_deadline[0] - now;
        expected_results.push_back(r);
    endfunction

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            armed      = 0;
            o_errors  <= 0;
            o_results <= 0;
            o_notices <= 0;
        end else begin
            if (i_in_valid && i_in_ready) predict_timers(i_in_data);
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (i_out_data.kind == 1'b0) o_notices <= o_notices + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    e = expected_results.pop_front();
                    if (e.kind !== i_out_data.kind
                        || e.expired_id !== i_out_data.expired_id
                        || e.next_interval_us !== i_out_data.next_interval_us
                        || e.queue_empty !== i_out_data.queue_empty
                        || e.last !== i_out_data.last) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, e, i_out_data);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sorted deadline timer queue
// Directed corner transactions, then random arm/cancel/tick traffic with
// random idling on both channels; a separate checker does the comparing.
// ----------------------------------------------------------------------------
module testbench;
    import sdtq_pkg::*;

    localparam int N_RANDOM = 81;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending, results, notices;
    int   sent;
    bit   quiet;
    logic [47:0] clock_us;

    sdtq_if #(.T(t_in_item))  in_ch();
    sdtq_if #(.T(t_out_item)) out_ch();

    sorted_deadline_timer_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch.sink),
        .o_item  (out_ch.source)
    );

    sdtq_tb_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_ch.valid),
        .i_in_ready  (in_ch.ready),
        .i_in_data   (in_ch.payload),
        .i_out_valid (out_ch.valid),
        .i_out_ready (out_ch.ready),
        .i_out_data  (out_ch.payload),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_notices   (notices)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver side: random stall bursts
    initial begin
        int n;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 15);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send(logic [1:0] mode, logic [ID_BITS-1:0] id,
                        logic [DELAY_BITS-1:0] dly, logic [47:0] now);
        int n;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            n = $urandom_range(1, 15);
            repeat (n) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= '{mode: mode, timer_id: id, delay_ms: dly, now_us: now};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    initial begin
        logic [1:0] m;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        quiet = 1'b0;
        sent  = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty-queue tick, unused mode, cancel of an idle id
        send(MODE_TICK, 4'd0, '0, 48'd0);
        send(2'd3, 4'hF, '1, '1);
        send(MODE_CANCEL, 4'd5, '0, 48'd100);
        // saturating deadline and maximal now, then equal deadlines, re-arm, cancel and ticks
        send(MODE_ARM, 4'hF, '1, '1);
        send(MODE_ARM, 4'd0, 24'd0, 48'd1000);
        send(MODE_ARM, 4'd1, 24'd0, 48'd1000);
        send(MODE_ARM, 4'd0, 24'd5, 48'd1000);
        send(MODE_CANCEL, 4'd1, '0, 48'd1000);
        send(MODE_TICK, 4'd0, '0, 48'd1000);
        send(MODE_TICK, 4'd0, '0, 48'd6001);
        // fill the queue, then re-arm while full, tick at maximal now and cancel
        for (int i = 0; i < NUM_TIMERS; i++)
            send(MODE_ARM, 4'(i), 24'(i * 3), 48'd2000);
        send(MODE_ARM, 4'd3, 24'd1, 48'd2000);
        send(MODE_TICK, 4'd0, '0, '1);
        send(MODE_CANCEL, 4'd7, '0, 48'h5555_5555_5555);

        clock_us = 48'd10_000;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k > N_RANDOM * 4 / 5) quiet = 1'b1;
            m = $urandom_range(0, 9) < 5 ? MODE_ARM :
                ($urandom_range(0, 2) == 0 ? MODE_CANCEL : MODE_TICK);
            if ($urandom_range(0, 20) == 0) m = 2'd3;
            clock_us = clock_us + 48'($urandom_range(0, 20000));
            if ($urandom_range(0, 15) == 0)
                send(m, 4'($urandom), 24'($urandom), 48'({$urandom, $urandom}));
            else
                send(m, 4'($urandom), 24'($urandom_range(0, 30)), clock_us);
        end
        in_ch.valid <= 1'b0;

        quiet = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("Sent %0d transactions; %0d results seen, %0d of them expiry notices.",
                 sent, results, notices);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/sdtq_pkg.sv
design/sdtq_if.sv
design/sdtq_datapath.sv
design/sdtq_ctrl.sv
design/sorted_deadline_timer_queue.sv
design/sdtq_checker.sv
dv/sdtq_checker.sv
dv/testbench.sv
